### src/bbhc_pkg.sv
package bbhc_pkg;

    // Operating modes.
    localparam logic [2:0] OPM_IDLE     = 3'd0;
    localparam logic [2:0] OPM_HEAT     = 3'd1;
    localparam logic [2:0] OPM_DHW      = 3'd2;
    localparam logic [2:0] OPM_HEAT_DHW = 3'd3;
    localparam logic [2:0] OPM_SUMMER   = 3'd4;
    localparam logic [2:0] OPM_SERVICE  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE             = 3'd0;
    localparam logic [2:0] REG_FLOW_TARGET_MIN  = 3'd1;
    localparam logic [2:0] REG_FLOW_TARGET_MAX  = 3'd2;
    localparam logic [2:0] REG_OVERHEAT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_FREEZE_LIMIT     = 3'd4;
    localparam logic [2:0] REG_BURNER_MIN_ON    = 3'd5;
    localparam logic [2:0] REG_BURNER_MIN_OFF   = 3'd6;
    localparam logic [2:0] REG_CONTROL_INTERVAL = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Top error codes.
    localparam logic [1:0] TOP_NONE     = 2'd0;
    localparam logic [1:0] TOP_OVERHEAT = 2'd1;
    localparam logic [1:0] TOP_FREEZE   = 2'd2;
    localparam logic [1:0] TOP_SENSOR   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] RST_FLOW_TARGET_MIN  = 16'sd480;
    localparam logic signed [15:0] RST_FLOW_TARGET_MAX  = 16'sd1280;
    localparam logic signed [15:0] RST_OVERHEAT_LIMIT   = 16'sd1440;
    localparam logic signed [15:0] RST_FREEZE_LIMIT     = 16'sd48;
    localparam logic [31:0]        RST_BURNER_MIN_ON    = 32'd60000;
    localparam logic [31:0]        RST_BURNER_MIN_OFF   = 32'd60000;
    localparam logic [31:0]        RST_CONTROL_INTERVAL = 32'd1000;

    // Temperatures in 1/16 degree units.
    localparam logic signed [15:0] SENSOR_LOW       = -16'sd800;
    localparam logic signed [15:0] SENSOR_HIGH      = 16'sd2400;
    localparam logic signed [17:0] TARGET_BASE      = 18'sd1120;
    localparam logic signed [17:0] HOT_WATER_TARGET = 18'sd1280;
    localparam logic signed [17:0] HYST_BAND        = 18'sd80;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] flow_temp;
        logic signed [15:0] outside_temp;
    } t_in_item;

    typedef struct packed {
        logic        burner_on;
        logic        heating_pump_on;
        logic        water_pump_on;
        logic [2:0]  active_errors;
        logic [1:0]  top_error;
        logic [15:0] error_events;
        logic        burner_started;
        logic        burner_stopped;
    } t_out_item;

endpackage

### src/boiler_burner_hysteresis_control.sv
// Boiler burner controller with hysteresis and minimum on and off times.
//
// Input channel: one beat per controller update, carrying the time in
// milliseconds and the flow and outside temperatures. A beat is taken on a
// rising edge with i_in_valid high and o_in_stall low. Output channel: one
// result beat per input beat, taken with o_out_valid high and i_out_stall low.
// Configuration channel: an index and a 32-bit data word, written on an edge
// with i_cfg_valid and o_cfg_ready both high. Writes are taken only while no
// update sits in the input register; configure only while the block is idle.
//
// Each beat passes the input register, then the safety and control logic,
// then the result register. Throughput is one beat per cycle while the receiver
// does not stall, since every update finishes its state change between those
// two registers. When the receiver stalls, the result register holds its beat
// and the input register fills; the input channel stalls only once both are
// occupied. A synchronous active-low reset empties both registers, clears all
// burner, pump, stamp and error state and loads the default configuration.
module boiler_burner_hysteresis_control (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bbhc_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bbhc_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbhc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bbhc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bbhc_pkg::*;

    // Configuration registers.
    logic [2:0]         r_mode;
    logic signed [15:0] r_flow_target_min;
    logic signed [15:0] r_flow_target_max;
    logic signed [15:0] r_overheat_limit;
    logic signed [15:0] r_freeze_limit;
    logic [31:0]        r_burner_min_on;
    logic [31:0]        r_burner_min_off;
    logic [31:0]        r_control_interval;

    // Controller state.
    logic        r_burner, n_burner;
    logic        r_heat_pump, n_heat_pump;
    logic        r_water_pump, n_water_pump;
    logic [31:0] r_start_stamp, n_start_stamp;
    logic [31:0] r_stop_stamp, n_stop_stamp;
    logic [31:0] r_last_ctrl, n_last_ctrl;
    logic [2:0]  r_last_errs, n_last_errs;
    logic [15:0] r_err_count, n_err_count;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    logic advance;
    logic in_take;
    logic step_fire;
    logic cfg_fire;

    // The result register can load when it is empty or its beat leaves now.
    assign advance     = !r_out_valid || !i_out_stall;
    assign in_take     = !r_in_valid || advance;
    assign step_fire   = r_in_valid && advance;
    assign o_in_stall  = !in_take;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Safety check and control decision for the update in the input register.
    logic               overheat;
    logic               freeze;
    logic               sensor_fault;
    logic [2:0]         errs;
    logic               burner_safe;
    logic               ctrl_due;
    logic signed [15:0] half_out;
    logic signed [17:0] comp_target;
    logic signed [17:0] clamp_target;
    logic signed [17:0] target;
    logic signed [17:0] flow_ext;
    logic signed [17:0] min_ext;
    logic signed [17:0] max_ext;
    logic               started;
    logic               stopped;
    logic [1:0]         top;

    always_comb begin
        overheat     = r_in_item.flow_temp > r_overheat_limit;
        freeze       = (r_in_item.outside_temp < r_freeze_limit) && (r_mode == OPM_IDLE);
        sensor_fault = (r_in_item.flow_temp < SENSOR_LOW) || (r_in_item.flow_temp > SENSOR_HIGH);
        errs         = {sensor_fault, freeze, overheat};
        // Overheat forces the burner off without counting as a hysteresis stop.
        burner_safe  = r_burner && !overheat;
        ctrl_due     = (r_in_item.now_ms - r_last_ctrl) >= r_control_interval;

        // Weather-compensated target: base minus half the outside value, floored.
        half_out    = r_in_item.outside_temp >>> 1;
        comp_target = TARGET_BASE - $signed({{2{half_out[15]}}, half_out});
        min_ext     = $signed({{2{r_flow_target_min[15]}}, r_flow_target_min});
        max_ext     = $signed({{2{r_flow_target_max[15]}}, r_flow_target_max});
        flow_ext    = $signed({{2{r_in_item.flow_temp[15]}}, r_in_item.flow_temp});
        // The lower bound is tested first, so it wins for any target below it, even when the bounds cross.
        priority if (comp_target < min_ext) begin
            clamp_target = min_ext;
        end else if (comp_target > max_ext) begin
            clamp_target = max_ext;
        end else begin
            clamp_target = comp_target;
        end
        target = (r_mode == OPM_DHW) ? HOT_WATER_TARGET : clamp_target;

        n_last_errs = r_last_errs;
        n_err_count = r_err_count;
        if (errs != 3'b000 && errs != r_last_errs) begin
            n_last_errs = errs;
            if (r_err_count != 16'hFFFF) begin
                n_err_count = r_err_count + 16'd1;
            end
        end

        n_burner      = burner_safe;
        n_heat_pump   = r_heat_pump;
        n_water_pump  = r_water_pump;
        n_start_stamp = r_start_stamp;
        n_stop_stamp  = r_stop_stamp;
        n_last_ctrl   = r_last_ctrl;
        started       = 1'b0;
        stopped       = 1'b0;

        if (ctrl_due) begin
            n_last_ctrl = r_in_item.now_ms;
            unique case (r_mode)
                OPM_HEAT, OPM_DHW, OPM_HEAT_DHW: begin
                    if (!burner_safe && (flow_ext < target - HYST_BAND)) begin
                        if ((r_in_item.now_ms - r_stop_stamp) >= r_burner_min_off) begin
                            n_burner      = 1'b1;
                            n_start_stamp = r_in_item.now_ms;
                            started       = 1'b1;
                        end
                    end else if (burner_safe && (flow_ext > target + HYST_BAND)) begin
                        if ((r_in_item.now_ms - r_start_stamp) >= r_burner_min_on) begin
                            n_burner     = 1'b0;
                            n_stop_stamp = r_in_item.now_ms;
                            stopped      = 1'b1;
                        end
                    end
                    if (r_mode == OPM_DHW) begin
                        n_water_pump = 1'b1;
                        n_heat_pump  = 1'b0;
                    end else begin
                        n_heat_pump = 1'b1;
                    end
                end
                OPM_SUMMER, OPM_SERVICE: begin
                    n_burner     = 1'b0;
                    n_heat_pump  = 1'b0;
                    n_water_pump = 1'b0;
                end
                default: begin
                    // Off mode only moves the control stamp.
                end
            endcase
        end

        priority if (errs[0]) begin
            top = TOP_OVERHEAT;
        end else if (errs[1]) begin
            top = TOP_FREEZE;
        end else if (errs[2]) begin
            top = TOP_SENSOR;
        end else begin
            top = TOP_NONE;
        end

        n_out_item.burner_on       = n_burner;
        n_out_item.heating_pump_on = n_heat_pump;
        n_out_item.water_pump_on   = n_water_pump;
        n_out_item.active_errors   = errs;
        n_out_item.top_error       = top;
        n_out_item.error_events    = n_err_count;
        n_out_item.burner_started  = started;
        n_out_item.burner_stopped  = stopped;
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (step_fire) begin
            r_out_item <= n_out_item;
        end
    end

    // Controller state and configuration. Writes are only taken while the
    // input register is empty, so they never meet a state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode             <= OPM_IDLE;
            r_flow_target_min  <= RST_FLOW_TARGET_MIN;
            r_flow_target_max  <= RST_FLOW_TARGET_MAX;
            r_overheat_limit   <= RST_OVERHEAT_LIMIT;
            r_freeze_limit     <= RST_FREEZE_LIMIT;
            r_burner_min_on    <= RST_BURNER_MIN_ON;
            r_burner_min_off   <= RST_BURNER_MIN_OFF;
            r_control_interval <= RST_CONTROL_INTERVAL;
            r_burner           <= 1'b0;
            r_heat_pump        <= 1'b0;
            r_water_pump       <= 1'b0;
            r_start_stamp      <= '0;
            r_stop_stamp       <= '0;
            r_last_ctrl        <= '0;
            r_last_errs        <= '0;
            r_err_count        <= '0;
        end else if (step_fire) begin
            r_burner      <= n_burner;
            r_heat_pump   <= n_heat_pump;
            r_water_pump  <= n_water_pump;
            r_start_stamp <= n_start_stamp;
            r_stop_stamp  <= n_stop_stamp;
            r_last_ctrl   <= n_last_ctrl;
            r_last_errs   <= n_last_errs;
            r_err_count   <= n_err_count;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_MODE: begin
                    // Out-of-range and unchanged modes are ignored; entering off
                    // mode drops the burner and both pumps at once.
                    if (i_cfg_data[2:0] <= OPM_SERVICE && i_cfg_data[2:0] != r_mode) begin
                        r_mode <= i_cfg_data[2:0];
                        if (i_cfg_data[2:0] == OPM_IDLE) begin
                            r_burner     <= 1'b0;
                            r_heat_pump  <= 1'b0;
                            r_water_pump <= 1'b0;
                        end
                    end
                end
                REG_FLOW_TARGET_MIN:  r_flow_target_min  <= $signed(i_cfg_data[15:0]);
                REG_FLOW_TARGET_MAX:  r_flow_target_max  <= $signed(i_cfg_data[15:0]);
                REG_OVERHEAT_LIMIT:   r_overheat_limit   <= $signed(i_cfg_data[15:0]);
                REG_FREEZE_LIMIT:     r_freeze_limit     <= $signed(i_cfg_data[15:0]);
                REG_BURNER_MIN_ON:    r_burner_min_on    <= i_cfg_data;
                REG_BURNER_MIN_OFF:   r_burner_min_off   <= i_cfg_data;
                REG_CONTROL_INTERVAL: r_control_interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
